// ===== rtl/cidc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cidc_pkg
// Shared constants for the command identifier duplicate suppression cache.
// ----------------------------------------------------------------------------
package cidc_pkg;

   localparam int ENTRIES_DEF   = 20;
   localparam int KEY_WORDS_DEF = 8;

   localparam int CHUNK_W    = 64;
   localparam int TIME_W     = 64;
   localparam int LIFE_W     = 32;
   localparam int SLOT_OUT_W = 5;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [LIFE_W-1:0] LIFETIME_RST = 32'd60000;

   // register index, taken from the word address bit of paddr
   localparam logic REG_LIFETIME = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/cidc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cidc_req_if / cidc_rsp_if
// Valid/ready channels for identifier chunks and lookup results.
// ----------------------------------------------------------------------------
interface cidc_req_if;
   import cidc_pkg::*;

   logic               valid;
   logic               ready;
   logic [CHUNK_W-1:0] id_chunk;
   logic               id_last;
   logic [TIME_W-1:0]  now_ms;

   modport source (output valid, output id_chunk, output id_last, output now_ms,
                   input ready);
   modport sink   (input valid, input id_chunk, input id_last, input now_ms,
                   output ready);
endinterface

interface cidc_rsp_if;
   import cidc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  is_duplicate;
   logic [SLOT_OUT_W-1:0] slot_used;

   modport source (output valid, output is_duplicate, output slot_used, input ready);
   modport sink   (input valid, input is_duplicate, input slot_used, output ready);
endinterface

`default_nettype wire

// ===== rtl/command_id_dedup_cache.sv =====
`default_nettype none
// Non-final chunks: one per cycle, accepted while the sequencer is idle.
// Final chunk: an expiry scan over every slot, a key scan over the single key memory
// port that stops at the first hit, a key write of KEY_WORDS words on a miss, and a reply.
// The key memory read port, one word per cycle, paces the key scan.
// Reset (synchronous): valid bits, assembly buffer and control cleared; no clearing pass.
// ----------------------------------------------------------------------------
// command_id_dedup_cache
// TTL duplicate suppression cache: expires old entries, matches identifiers,
// refreshes hits and stores misses in a free or the oldest slot.
// ----------------------------------------------------------------------------
module command_id_dedup_cache #(
   parameter int ENTRIES   = cidc_pkg::ENTRIES_DEF,
   parameter int KEY_WORDS = cidc_pkg::KEY_WORDS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   cidc_req_if.sink                             req_chan,
   cidc_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [cidc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [cidc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [cidc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import cidc_pkg::*;

   localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int WORD_W  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   localparam int CNT_W   = $clog2(KEY_WORDS + 1);
   localparam int KDEPTH  = ENTRIES * KEY_WORDS;
   localparam int KADDR_W = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);
   localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(KEY_WORDS - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(KEY_WORDS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPIRE,
      ST_MATCH,
      ST_STORE,
      ST_REPLY
   } state_type;

   state_type state_ff, state_in;

   logic [LIFE_W-1:0]     lifetime_ff, lifetime_in;
   logic [CHUNK_W-1:0]    incoming_id_ff [KEY_WORDS];
   logic [CHUNK_W-1:0]    incoming_id_in [KEY_WORDS];
   logic [CNT_W-1:0]      chunk_count_ff, chunk_count_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [ENTRIES-1:0]    valid_ff, valid_in;

   logic [SLOT_W-1:0]     rd_slot_ff, rd_slot_in;
   logic [WORD_W-1:0]     rd_word_ff, rd_word_in;
   logic                  rd_active_ff, rd_active_in;
   logic [SLOT_W-1:0]     chk_slot_ff, chk_slot_in;
   logic [WORD_W-1:0]     chk_word_ff, chk_word_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic                  eq_acc_ff, eq_acc_in;

   logic                  free_found_ff, free_found_in;
   logic [SLOT_W-1:0]     free_slot_ff, free_slot_in;
   logic [TIME_W-1:0]     oldest_ff, oldest_in;
   logic [SLOT_W-1:0]     oldest_slot_ff, oldest_slot_in;

   logic                  result_dup_ff, result_dup_in;
   logic [SLOT_W-1:0]     result_slot_ff, result_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_dup_ff, rsp_dup_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // memory read data
   logic [CHUNK_W-1:0]    key_rd_ff;
   logic [TIME_W-1:0]     time_rd_ff;

   logic                  req_fire;
   logic                  csr_write;
   logic                  key_we;
   logic [SLOT_W-1:0]     key_slot;
   logic [WORD_W-1:0]     key_word;
   logic [KADDR_W-1:0]    key_addr;
   logic                  time_we;
   logic [SLOT_W-1:0]     time_waddr;
   logic [SLOT_W-1:0]     victim;
   logic [TIME_W-1:0]     age;
   logic                  live;
   logic                  word_eq;
   logic                  eq_now;
   logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

   logic [CHUNK_W-1:0] key_mem  [KDEPTH];
   logic [TIME_W-1:0]  time_mem [ENTRIES];

   assign req_fire  = req_chan.valid && (state_ff == ST_IDLE);
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.is_duplicate = rsp_dup_ff;
   assign rsp_chan.slot_used    = rsp_slot_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_LIFETIME) ? lifetime_ff : '0;

   assign victim   = free_found_ff ? free_slot_ff : oldest_slot_ff;
   assign age      = now_ff - time_rd_ff;
   assign live     = valid_ff[chk_slot_ff] && !(age > TIME_W'(lifetime_ff));
   assign word_eq  = (key_rd_ff == incoming_id_ff[chk_word_ff]);
   assign eq_now   = (chk_word_ff == WORD_W'(0)) ? word_eq : (eq_acc_ff && word_eq);
   assign key_addr = KADDR_W'(key_slot) * KADDR_W'(KEY_WORDS) + KADDR_W'(key_word);
   assign slot_ext = {{SLOT_OUT_W{1'b0}}, result_slot_ff};

   always_comb begin
      state_in       = state_ff;
      lifetime_in    = lifetime_ff;
      incoming_id_in = incoming_id_ff;
      chunk_count_in = chunk_count_ff;
      now_in         = now_ff;
      valid_in       = valid_ff;
      rd_slot_in     = rd_slot_ff;
      rd_word_in     = rd_word_ff;
      rd_active_in   = rd_active_ff;
      chk_slot_in    = chk_slot_ff;
      chk_word_in    = chk_word_ff;
      chk_vld_in     = chk_vld_ff;
      eq_acc_in      = eq_acc_ff;
      free_found_in  = free_found_ff;
      free_slot_in   = free_slot_ff;
      oldest_in      = oldest_ff;
      oldest_slot_in = oldest_slot_ff;
      result_dup_in  = result_dup_ff;
      result_slot_in = result_slot_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_dup_in     = rsp_dup_ff;
      rsp_slot_in    = rsp_slot_ff;
      key_we         = 1'b0;
      key_slot       = rd_slot_ff;
      key_word       = rd_word_ff;
      time_we        = 1'b0;
      time_waddr     = chk_slot_ff;

      if (csr_write && csr_paddr[2] == REG_LIFETIME) begin
         lifetime_in = csr_pwdata;
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // the check stage handles each read in the cycle after it is issued
      if (state_ff == ST_EXPIRE || state_ff == ST_MATCH) begin
         chk_vld_in  = rd_active_ff;
         chk_slot_in = rd_slot_ff;
         chk_word_in = rd_word_ff;
         if (rd_active_ff) begin
            if (state_ff == ST_EXPIRE || rd_word_ff == LAST_WORD) begin
               rd_word_in = '0;
               if (rd_slot_ff == LAST_SLOT) begin
                  rd_active_in = 1'b0;
               end else begin
                  rd_slot_in = rd_slot_ff + SLOT_W'(1);
               end
            end else begin
               rd_word_in = rd_word_ff + WORD_W'(1);
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (chunk_count_ff < CNT_FULL) begin
                  incoming_id_in[chunk_count_ff[WORD_W-1:0]] = req_chan.id_chunk;
                  chunk_count_in = chunk_count_ff + CNT_W'(1);
               end
               if (req_chan.id_last) begin
                  now_in        = req_chan.now_ms;
                  state_in      = ST_EXPIRE;
                  rd_slot_in    = '0;
                  rd_word_in    = '0;
                  rd_active_in  = 1'b1;
                  chk_vld_in    = 1'b0;
                  free_found_in = 1'b0;
               end
            end
         end
         ST_EXPIRE: begin
            if (chk_vld_ff) begin
               valid_in[chk_slot_ff] = live;
               if (!live && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = chk_slot_ff;
               end
               // oldest only matters when every slot stays live
               if (chk_slot_ff == SLOT_W'(0) || time_rd_ff < oldest_ff) begin
                  oldest_in      = time_rd_ff;
                  oldest_slot_in = chk_slot_ff;
               end
               if (chk_slot_ff == LAST_SLOT) begin
                  state_in     = ST_MATCH;
                  rd_slot_in   = '0;
                  rd_word_in   = '0;
                  rd_active_in = 1'b1;
                  chk_vld_in   = 1'b0;
               end
            end
         end
         ST_MATCH: begin
            if (chk_vld_ff) begin
               eq_acc_in = eq_now;
               if (chk_word_ff == LAST_WORD) begin
                  if (valid_ff[chk_slot_ff] && eq_now) begin
                     time_we        = 1'b1;
                     time_waddr     = chk_slot_ff;
                     result_dup_in  = 1'b1;
                     result_slot_in = chk_slot_ff;
                     state_in       = ST_REPLY;
                     rd_active_in   = 1'b0;
                     chk_vld_in     = 1'b0;
                  end else if (chk_slot_ff == LAST_SLOT) begin
                     result_dup_in  = 1'b0;
                     result_slot_in = victim;
                     state_in       = ST_STORE;
                     rd_active_in   = 1'b0;
                     chk_vld_in     = 1'b0;
                     chk_word_in    = '0;
                  end
               end
            end
         end
         ST_STORE: begin
            key_we   = 1'b1;
            key_slot = victim;
            key_word = chk_word_ff;
            if (chk_word_ff == LAST_WORD) begin
               time_we          = 1'b1;
               time_waddr       = victim;
               valid_in[victim] = 1'b1;
               state_in         = ST_REPLY;
            end else begin
               chk_word_in = chk_word_ff + WORD_W'(1);
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_dup_in     = result_dup_ff;
               rsp_slot_in    = slot_ext[SLOT_OUT_W-1:0];
               chunk_count_in = '0;
               for (int w = 0; w < KEY_WORDS; w++) begin
                  incoming_id_in[w] = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         lifetime_ff    <= LIFETIME_RST;
         chunk_count_ff <= '0;
         valid_ff       <= '0;
         rd_active_ff   <= 1'b0;
         chk_vld_ff     <= 1'b0;
         free_found_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int w = 0; w < KEY_WORDS; w++) begin
            incoming_id_ff[w] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         lifetime_ff    <= lifetime_in;
         chunk_count_ff <= chunk_count_in;
         valid_ff       <= valid_in;
         rd_active_ff   <= rd_active_in;
         chk_vld_ff     <= chk_vld_in;
         free_found_ff  <= free_found_in;
         rsp_valid_ff   <= rsp_valid_in;
         incoming_id_ff <= incoming_id_in;
      end
      now_ff         <= now_in;
      rd_slot_ff     <= rd_slot_in;
      rd_word_ff     <= rd_word_in;
      chk_slot_ff    <= chk_slot_in;
      chk_word_ff    <= chk_word_in;
      eq_acc_ff      <= eq_acc_in;
      free_slot_ff   <= free_slot_in;
      oldest_ff      <= oldest_in;
      oldest_slot_ff <= oldest_slot_in;
      result_dup_ff  <= result_dup_in;
      result_slot_ff <= result_slot_in;
      rsp_dup_ff     <= rsp_dup_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   // key store: one port, one address per cycle for both the write and the read
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_addr] <= incoming_id_ff[chk_word_ff];
      end
      key_rd_ff <= key_mem[key_addr];
   end

   // timestamp store
   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[time_waddr] <= now_ff;
      end
      time_rd_ff <= time_mem[rd_slot_ff];
   end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the command identifier duplicate suppression cache. Identifier chunks
// are fed over the request channel with random gaps, and every final chunk is
// run through a cycle-free copy of the cache (expiry, match, free or oldest
// slot). Each lookup result is compared in order against that prediction while
// the lifetime register is swept between phases.
// ----------------------------------------------------------------------------
module testbench;
   import cidc_pkg::*;

   localparam int ENTRIES     = ENTRIES_DEF;
   localparam int KEY_WORDS   = KEY_WORDS_DEF;
   localparam int MAX_CHUNKS  = KEY_WORDS + 2;
   localparam int POOL_MAX    = 40;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 305;
   localparam int SETTLE_CYC  = 220;
   localparam int LONG_HOLD   = 1500;
   localparam int HOLD_AFTER  = 60;
   localparam int CYCLE_LIMIT = 4000000;

   localparam logic [CSR_ADDR_W-1:0] LIFETIME_ADDR = {REG_LIFETIME, 2'b00};

   typedef struct {
      logic [CHUNK_W-1:0] id_chunk;
      logic               id_last;
      logic [TIME_W-1:0]  now_ms;
      bit                 wait_drain;
   } chunk_item_type;

   typedef struct {
      logic                  is_duplicate;
      logic [SLOT_OUT_W-1:0] slot_used;
   } lookup_result_type;

   logic clock;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cidc_req_if req_bus ();
   cidc_rsp_if rsp_bus ();

   command_id_dedup_cache u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // cache shadow
   logic [CHUNK_W-1:0] key_mem [ENTRIES][KEY_WORDS];
   logic [TIME_W-1:0]  stamp [ENTRIES];
   bit                 live [ENTRIES];
   logic [CHUNK_W-1:0] asm_words [KEY_WORDS];
   int                 asm_count;
   logic [LIFE_W-1:0]  lifetime_ms;

   chunk_item_type    chunk_q [$];
   lookup_result_type lookup_expect_q [$];

   int  errors;
   int  results_seen;
   int  cycle_count;
   int  idle_pct;
   int  gap_left;
   int  stall_left;
   int  hold_left;
   bit  hold_done;
   bit  req_taken;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [CHUNK_W-1:0] rand_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Folds one chunk into the assembly buffer; on the final chunk runs the
   // expire / match / allocate sequence and queues the expected result.
   function automatic void absorb_chunk(input logic [CHUNK_W-1:0] chunk, input logic last,
                                        input logic [TIME_W-1:0] now);
      lookup_result_type res;
      int                victim;
      logic [TIME_W-1:0] oldest;
      bit                found;
      bit                hit;
      if (asm_count < KEY_WORDS) begin
         asm_words[asm_count] = chunk;
         asm_count++;
      end
      if (!last) return;
      for (int i = 0; i < ENTRIES; i++) begin
         if (live[i] && (now - stamp[i]) > {32'd0, lifetime_ms}) live[i] = 1'b0;
      end
      found  = 1'b0;
      victim = 0;
      for (int i = 0; i < ENTRIES && !found; i++) begin
         hit = live[i];
         for (int w = 0; w < KEY_WORDS; w++) begin
            if (key_mem[i][w] != asm_words[w]) hit = 1'b0;
         end
         if (hit) begin
            found  = 1'b1;
            victim = i;
         end
      end
      if (found) begin
         stamp[victim]    = now;
         res.is_duplicate = 1'b1;
      end else begin
         victim = -1;
         for (int i = 0; i < ENTRIES && victim < 0; i++) begin
            if (!live[i]) victim = i;
         end
         if (victim < 0) begin
            // cache full: lowest timestamp goes, lowest index on a tie
            victim = 0;
            oldest = '1;
            for (int i = 0; i < ENTRIES; i++) begin
               if (stamp[i] < oldest) begin
                  oldest = stamp[i];
                  victim = i;
               end
            end
         end
         for (int w = 0; w < KEY_WORDS; w++) key_mem[victim][w] = asm_words[w];
         stamp[victim]    = now;
         live[victim]     = 1'b1;
         res.is_duplicate = 1'b0;
      end
      res.slot_used = SLOT_OUT_W'(victim);
      lookup_expect_q.push_back(res);
      for (int w = 0; w < KEY_WORDS; w++) asm_words[w] = '0;
      asm_count = 0;
   endfunction

   task automatic push_chunk(input logic [CHUNK_W-1:0] chunk, input logic last,
                             input logic [TIME_W-1:0] now, input bit drain);
      chunk_item_type it;
      it.id_chunk   = chunk;
      it.id_last    = last;
      it.now_ms     = last ? now : {$urandom, $urandom};
      it.wait_drain = drain;
      chunk_q.push_back(it);
   endtask

   task automatic wait_idle();
      while (chunk_q.size() != 0 || lookup_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_lifetime(input logic [LIFE_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= LIFETIME_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      lifetime_ms = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Identifiers come from a small pool so that hits, refreshes, expiry and
   // full-cache replacement all show up; some are resent zero padded or with
   // chunks past the key width, which must map to the same key.
   task automatic fill_random_phase(input int n_chunks, input logic [TIME_W-1:0] base,
                                    input logic [LIFE_W-1:0] life);
      logic [CHUNK_W-1:0] pool_words [POOL_MAX][MAX_CHUNKS];
      int                 pool_len [POOL_MAX];
      int                 pool_n;
      int                 sent;
      int                 pick;
      int                 len;
      int                 extra;
      int                 variant;
      int                 r;
      bit                 drain;
      logic [TIME_W-1:0]  t;
      logic [CHUNK_W-1:0] word;
      pool_n = $urandom_range(8, 36);
      for (int p = 0; p < POOL_MAX; p++) begin
         pool_len[p] = ($urandom_range(9) == 0) ? $urandom_range(KEY_WORDS + 1, MAX_CHUNKS)
                                                : $urandom_range(1, KEY_WORDS);
         for (int j = 0; j < MAX_CHUNKS; j++) pool_words[p][j] = rand_word();
      end
      t    = base;
      sent = 0;
      while (sent < n_chunks) begin
         pick    = $urandom_range(pool_n - 1);
         variant = $urandom_range(9);
         if (variant == 2) begin
            for (int j = 0; j < MAX_CHUNKS; j++) pool_words[pick][j] = rand_word();
         end
         len   = pool_len[pick];
         extra = 0;
         if (variant == 0 && len < KEY_WORDS) extra = 1;
         if (variant == 1 && len >= KEY_WORDS) extra = $urandom_range(1, 2);
         r = $urandom_range(99);
         if (r < 4)
            t = t - {32'd0, $urandom};
         else if (r < 12)
            t = t + {32'd0, life} + 64'd1 + $urandom_range(0, 1000);
         else
            t = t + $urandom_range(0, life / 6);
         drain = ($urandom_range(199) == 0);
         for (int j = 0; j < len + extra; j++) begin
            if (j < len)
               word = pool_words[pick][j];
            else
               word = (variant == 0) ? '0 : rand_word();
            push_chunk(word, j == len + extra - 1, t, drain && j == 0);
         end
         sent += len + extra;
      end
   endtask

   // request driver: sampled at the rising edge, driven at the falling edge
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         absorb_chunk(req_bus.id_chunk, req_bus.id_last, req_bus.now_ms);
         void'(chunk_q.pop_front());
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (chunk_q.size() == 0 ||
                      (chunk_q[0].wait_drain && lookup_expect_q.size() != 0)) begin
            req_bus.valid <= 1'b0;
         end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap_left = $urandom_range(0, 15);
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid    <= 1'b1;
            req_bus.id_chunk <= chunk_q[0].id_chunk;
            req_bus.id_last  <= chunk_q[0].id_last;
            req_bus.now_ms   <= chunk_q[0].now_ms;
         end
      end
   end

   // result receiver, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         stall_left = $urandom_range(0, 15);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      lookup_result_type exp_res;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (lookup_expect_q.size() == 0) begin
            $display("%0t: unexpected transaction is_duplicate=%0b slot_used=%0d",
                     $time, rsp_bus.is_duplicate, rsp_bus.slot_used);
            errors++;
         end else begin
            exp_res = lookup_expect_q.pop_front();
            if (rsp_bus.is_duplicate !== exp_res.is_duplicate) begin
               $display("%0t: is_duplicate expected %0b actual %0b", $time,
                        exp_res.is_duplicate, rsp_bus.is_duplicate);
               errors++;
            end
            if (rsp_bus.slot_used !== exp_res.slot_used) begin
               $display("%0t: slot_used expected %0d actual %0d", $time,
                        exp_res.slot_used, rsp_bus.slot_used);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("command_id_dedup_cache: mismatch");
         $finish;
      end
   end

   initial begin
      logic [LIFE_W-1:0] life;
      logic [TIME_W-1:0] base;
      logic [CHUNK_W-1:0] long_id [MAX_CHUNKS];
      reset            = 1'b1;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      req_bus.valid    = 1'b0;
      req_bus.id_chunk = '0;
      req_bus.id_last  = 1'b0;
      req_bus.now_ms   = '0;
      rsp_bus.ready    = 1'b0;
      errors           = 0;
      results_seen     = 0;
      cycle_count      = 0;
      idle_pct         = 20;
      gap_left         = 0;
      stall_left       = 0;
      hold_left        = 0;
      hold_done        = 1'b0;
      req_taken        = 1'b0;
      asm_count        = 0;
      lifetime_ms      = LIFETIME_RST;
      for (int i = 0; i < ENTRIES; i++) begin
         live[i]  = 1'b0;
         stamp[i] = '0;
      end
      for (int w = 0; w < KEY_WORDS; w++) asm_words[w] = '0;
      for (int j = 0; j < MAX_CHUNKS; j++) long_id[j] = {$urandom, $urandom};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, lifetime at its reset value
      push_chunk('1, 1'b1, 64'd0, 1'b0);
      push_chunk('1, 1'b1, 64'd10, 1'b0);
      push_chunk('1, 1'b0, 64'd0, 1'b0);       // trailing zero chunk: same key
      push_chunk('0, 1'b1, 64'd20, 1'b0);
      push_chunk('0, 1'b1, 64'd30, 1'b0);      // all-zero key
      for (int j = 0; j < MAX_CHUNKS; j++) push_chunk(long_id[j], j == MAX_CHUNKS - 1,
                                                      64'd40, 1'b0);
      long_id[KEY_WORDS] = ~long_id[KEY_WORDS];  // differs past the key width only
      for (int j = 0; j <= KEY_WORDS; j++) push_chunk(long_id[j], j == KEY_WORDS,
                                                      64'd50, 1'b0);
      push_chunk('1, 1'b1, 64'd5, 1'b0);       // time went backward: everything expires
      wait_idle();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin life = 32'd1;        base = {$urandom, $urandom};  idle_pct = 25; end
            1: begin life = 32'hFFFF_FFFF; base = 64'hFFFF_FFFF_0000_0000; idle_pct = 10; end
            2: begin life = 32'd250;      base = '0;                     idle_pct = 40; end
            3: begin life = 32'd60000;    base = '1;                     idle_pct = 0;  end
            4: begin life = 32'd7;        base = {$urandom, $urandom};  idle_pct = 15; end
            default: begin life = 32'd1000; base = {$urandom, $urandom}; idle_pct = 0; end
         endcase
         write_lifetime(life);
         fill_random_phase(PHASE_ITEMS, base, life);
         wait_idle();
      end

      if (errors == 0)
         $display("command_id_dedup_cache: match");
      else
         $display("command_id_dedup_cache: mismatch");
      $finish;
   end

endmodule

// ===== command_id_dedup_cache.f =====
rtl/cidc_pkg.sv
rtl/cidc_if.sv
rtl/command_id_dedup_cache.sv
tb/testbench.sv
